// ----- rtl/fisher_yates_shuffle_xorshift_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef FISHER_YATES_SHUFFLE_XORSHIFT_UNIT_MACROS_SVH
`define FISHER_YATES_SHUFFLE_XORSHIFT_UNIT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define FYS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define FYS_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fys_pkg.sv -----
`default_nettype none

package fys_pkg;

  // Generator word and element port widths.
  localparam int RNG_W       = 64;
  localparam int ELEM_PORT_W = 8;

  // Xorshift64 shift amounts.
  localparam int XS_A = 13;
  localparam int XS_B = 7;
  localparam int XS_C = 17;

  // Command codes of the input channel.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  // One xorshift64 step.
  function automatic logic [RNG_W-1:0] xorshift(input logic [RNG_W-1:0] x);
    logic [RNG_W-1:0] t;
    t = x ^ (x << XS_A);
    t = t ^ (t >> XS_B);
    t = t ^ (t << XS_C);
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fys_if.sv -----
`default_nettype none

// Input channel: commands, elements and seeds.
interface fys_in_if;
  import fys_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [ELEM_PORT_W-1:0] element;
  logic [RNG_W-1:0]       seed;
  logic                   final_req;

  modport source (output valid, command, element, seed, final_req, input ready);
  modport sink   (input valid, command, element, seed, final_req, output ready);
endinterface

// Output channel: shuffled elements in index order.
interface fys_out_if;
  import fys_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ELEM_PORT_W-1:0] shuffled_element;
  logic                   end_of_list;

  modport source (output valid, shuffled_element, end_of_list, input ready);
  modport sink   (input valid, shuffled_element, end_of_list, output ready);
endinterface

`default_nettype wire

// ----- rtl/fys_ram.sv -----
`default_nettype none

module fys_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/fys_modu.sv -----
`default_nettype none

module fys_modu #(
  parameter int DW = 7
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [fys_pkg::RNG_W-1:0]  dividend,
  input  wire logic [DW-1:0]              divisor,
  output logic                            done,
  output logic      [DW-1:0]              remainder
);
  import fys_pkg::*;

  localparam int CNT_W = $clog2(RNG_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RNG_W-1:0] dvd;
  logic [DW-1:0]    dsr;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic [DW-1:0]    rem_next;

  // Restoring step: bring in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {remainder, dvd[RNG_W-1]};
    diff  = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      rem_next = diff[DW-1:0];
    end else begin
      rem_next = trial[DW-1:0];
    end
  end

  // Control: one dividend bit per cycle, done pulses after the last bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '1;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd       <= dvd << 1;
      remainder <= rem_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fisher_yates_shuffle_xorshift_unit.sv -----
`default_nettype none
// Seed loads and non-final element loads leave the block ready again.
// A final load shuffles a list of n elements with n-1 swaps: each swap is one
// generator step, a run of the bit-serial modulo unit, RAM reads of i and j and then
// writes of i and j; emitting reads each element from RAM into the output register.
// Reset clears the sequencer, list count and output valid and sets the generator
// state to one; the list RAM is not cleared.

module fisher_yates_shuffle_xorshift_unit #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 8
) (
  input wire logic   clk,
  input wire logic   rst,
  fys_in_if.sink     in_ch,
  fys_out_if.source  out_ch
);
  import fys_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RNG,
    S_MOD,
    S_RD_I,
    S_RD_J,
    S_WR_I,
    S_WR_J,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [RNG_W-1:0]       rng;
  logic [AW-1:0]          idx_i;
  logic [AW-1:0]          idx_j;
  logic [AW-1:0]          idx_k;
  logic [ELEM_WIDTH-1:0]  held_i;
  logic                   out_valid;
  logic [ELEM_PORT_W-1:0] out_elem;
  logic                   out_eol;

  logic [RNG_W-1:0]       rng_next;
  logic                   in_xfer;
  logic [CW-1:0]          count_inc;
  logic [31:0]            elem32;
  logic [31:0]            rd32;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [ELEM_WIDTH-1:0]  wdata;
  logic [AW-1:0]          raddr;
  logic [ELEM_WIDTH-1:0]  rdata;
  logic                   mod_start;
  logic                   mod_done;
  logic [CW-1:0]          mod_rem;
  logic [CW-1:0]          divisor;
  logic                   out_free;

  assign in_ch.ready             = (state == S_IDLE);
  assign in_xfer                 = in_ch.valid && in_ch.ready;
  assign out_ch.valid            = out_valid;
  assign out_ch.shuffled_element = out_elem;
  assign out_ch.end_of_list      = out_eol;
  assign out_free                = !out_valid || out_ch.ready;

  assign rng_next  = xorshift(rng);
  assign count_inc = (count < CW'(DEPTH)) ? count + CW'(1) : count;
  assign elem32    = 32'(in_ch.element);
  assign rd32      = 32'(rdata);
  assign mod_start = (state == S_RNG);
  assign divisor   = CW'(idx_i) + CW'(1);

  // RAM port selection: loads and swap writes share the write port.
  always_comb begin
    we    = 1'b0;
    waddr = idx_i;
    wdata = rdata;
    raddr = idx_i;
    unique case (state) inside
      S_IDLE: begin
        we    = in_xfer && (in_ch.command == CMD_LOAD) && (count < CW'(DEPTH));
        waddr = count[AW-1:0];
        wdata = elem32[ELEM_WIDTH-1:0];
      end
      S_RD_J: begin
        raddr = idx_j;
      end
      S_WR_I: begin
        we = 1'b1;
      end
      S_WR_J: begin
        we    = 1'b1;
        waddr = idx_j;
        wdata = held_i;
      end
      S_EMIT_RD, S_EMIT_LD: begin
        raddr = idx_k;
      end
      default: begin
      end
    endcase
  end

  fys_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  fys_modu #(
    .DW (CW)
  ) u_modu (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (rng_next),
    .divisor   (divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Sequencer with the list count, generator state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rng       <= RNG_W'(1);
      out_valid <= 1'b0;
    end else begin
      // The load state sets the output valid itself when it refills the register.
      if (out_ch.ready && (state != S_EMIT_LD)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_ch.command == CMD_SEED) begin
              rng <= (in_ch.seed == '0) ? RNG_W'(1) : in_ch.seed;
            end else begin
              count <= count_inc;
              if (in_ch.final_req) begin
                idx_k <= '0;
                if (count_inc == CW'(1)) begin
                  state <= S_EMIT_RD;
                end else begin
                  idx_i <= AW'(count_inc - CW'(1));
                  state <= S_RNG;
                end
              end
            end
          end
        end
        S_RNG: begin
          rng   <= rng_next;
          state <= S_MOD;
        end
        S_MOD: begin
          if (mod_done) begin
            idx_j <= mod_rem[AW-1:0];
            state <= S_RD_I;
          end
        end
        S_RD_I: begin
          state <= S_RD_J;
        end
        S_RD_J: begin
          held_i <= rdata;
          state  <= S_WR_I;
        end
        S_WR_I: begin
          state <= S_WR_J;
        end
        S_WR_J: begin
          if (idx_i == AW'(1)) begin
            state <= S_EMIT_RD;
          end else begin
            idx_i <= idx_i - AW'(1);
            state <= S_RNG;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_elem  <= rd32[ELEM_PORT_W-1:0];
            if (idx_k == AW'(count - CW'(1))) begin
              out_eol <= 1'b1;
              count   <= '0;
              state   <= S_IDLE;
            end else begin
              out_eol <= 1'b0;
              idx_k   <= idx_k + AW'(1);
              state   <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fys_chk.sv -----
`default_nettype none
`include "fisher_yates_shuffle_xorshift_unit_macros.svh"

module fys_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            in_command,
  input wire logic                            in_final,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [fys_pkg::ELEM_PORT_W-1:0] out_element,
  input wire logic                            out_eol
);
  import fys_pkg::*;

  // A stalled result stays offered.
  `FYS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "output valid dropped while stalled")

  // A stalled result keeps its payload.
  `FYS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_element) && $stable(out_eol), "output payload changed while stalled")

  // A final element transfer starts the shuffle or the output, so input is not taken next cycle.
  `FYS_ASSERT_NEXT(a_final_busy, clk, rst, in_valid && in_ready && (in_command == CMD_LOAD) && in_final, !in_ready, "ready stayed high after a final element")

  // An idle cycle or a seed transfer never produces a new result.
  `FYS_ASSERT_NEXT(a_no_spurious, clk, rst, in_ready && (!in_valid || (in_command == CMD_SEED)) && !out_valid, !out_valid, "result appeared without a final element")

endmodule

bind fisher_yates_shuffle_xorshift_unit fys_chk u_fys_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_command  (in_ch.command),
  .in_final    (in_ch.final_req),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_element (out_ch.shuffled_element),
  .out_eol     (out_ch.end_of_list)
);

`default_nettype wire
